/* hdl/fire_pkg.sv */
// Shared types, constants and the color palette of the fire effect cell engine.
`default_nettype none

package fire_pkg;

  // Fixed field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned RND_W     = 2;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RGB_W     = 24;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_W-1:0]     COLS_RST = 8'd110;
  localparam logic [CFG_W-1:0]     ROWS_RST = 8'd80;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_RESEED = 2'd0,
    OP_SPREAD = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // Palette: 37 entries, heat above the last entry uses the last one
  localparam int unsigned PAL_LAST  = 36;
  localparam int unsigned PAL_IDX_W = 6;
  localparam logic [RGB_W-1:0] PAL_TAB [0:PAL_LAST] = '{
    24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
    24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
    24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
    24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
    24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
    24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
    24'hFFFFFF
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic clr_start;  // restart clear counter and scan position
    logic clr_wr;     // write one clear entry and advance
    logic rd_calc;    // compute read address and range flag
    logic rd_mem;     // read the store at the read address
    logic sp_rd;      // read the scan source cell
    logic sp_wr;      // write the target cell and advance the scan
    logic out_load;   // load the output register
  } fire_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cfg_wr;     // a register write to a listed register
    logic clr_last;   // clear counter sits on the last entry
    logic rows_lt2;   // a single row: nothing to spread
  } fire_sts_t;

endpackage

`default_nettype wire

/* hdl/fire_effect_cell_engine.sv */
// Top level of the fire effect cell engine: controller plus datapath.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_stall_o  opcode_i, rnd_i, read_col_i, read_row_i
//  out      output     out_valid_o/out_stall_i heat_o, color_rgb_o, frame_done_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  Spread steps: accept, read source, write target, load result. Read steps: accept, address
//  multiply, store read, load result. An unused opcode and a single-row spread go from accept
//  straight to load result. A stalled output adds its stall.
//  The heat store is single-port: one access per cycle.
//  Reset, a reseed and a write to the column or row register run a clearing pass over all
//  MAX_COLS*MAX_ROWS store entries with in_stall_o high; a reseed answers after it.
//  A result waits in the output register while the next item is accepted.
`default_nettype none

module fire_effect_cell_engine #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned HEAT_MAX = 36,
  localparam int unsigned HEAT_W  = $clog2(HEAT_MAX + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [fire_pkg::OP_W-1:0]       opcode_i,
  input  wire logic [fire_pkg::RND_W-1:0]      rnd_i,
  input  wire logic [fire_pkg::POS_W-1:0]      read_col_i,
  input  wire logic [fire_pkg::POS_W-1:0]      read_row_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [HEAT_W-1:0]                    heat_o,
  output logic [fire_pkg::RGB_W-1:0]           color_rgb_o,
  output logic                                 frame_done_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fire_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fire_pkg::CFG_W-1:0]      cfg_data_i
);
  import fire_pkg::*;

  fire_cmd_t cmd;
  fire_sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  fire_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fire_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .HEAT_MAX (HEAT_MAX)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .opcode_i     (opcode_i),
    .rnd_i        (rnd_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .heat_o       (heat_o),
    .color_rgb_o  (color_rgb_o),
    .frame_done_o (frame_done_o)
  );

  // One item at a time: an accepted item blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two cycles in a row");

  // A write to the column or row register starts the clearing pass, which blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_COLS || cfg_index_i == REG_ROWS)
    |=> in_stall_o)
    else $error("input not blocked after a register write");

  // A frame end comes only from a spread, which carries no heat or color
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> heat_o == '0 && color_rgb_o == '0)
    else $error("frame end with read data");

  // Heat never exceeds the source value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(heat_o) <= HEAT_MAX)
    else $error("heat above the source value");

endmodule

`default_nettype wire

/* hdl/fire_ctrl.sv */
// Controller state machine of the fire effect cell engine.
`default_nettype none

module fire_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [fire_pkg::OP_W-1:0]  opcode_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire fire_pkg::fire_sts_t        sts_i,
  output fire_pkg::fire_cmd_t             cmd_o
);
  import fire_pkg::*;

  typedef enum logic [2:0] {
    ST_PREP,
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_SP_RD,
    ST_SP_WR,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   pend_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode commands from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.clr_start = (state_q == ST_PREP);
    cmd_o.clr_wr    = (state_q == ST_CLEAR);
    cmd_o.rd_calc   = (state_q == ST_RD_ADDR);
    cmd_o.rd_mem    = (state_q == ST_RD_MEM);
    cmd_o.sp_rd     = (state_q == ST_SP_RD);
    cmd_o.sp_wr     = (state_q == ST_SP_WR);
    cmd_o.out_load  = (state_q == ST_FINISH) && out_free;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Hold state, pending reseed result and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PREP;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Output register: set on load, drop on a transfer
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (sts_i.cfg_wr) begin
        state_q <= ST_PREP;
      end else begin
        case (state_q)
          ST_PREP: begin
            state_q <= ST_CLEAR;
          end
          ST_CLEAR: begin
            if (sts_i.clr_last) begin
              state_q <= pend_q ? ST_FINISH : ST_IDLE;
              pend_q  <= 1'b0;
            end
          end
          ST_IDLE: begin
            if (in_valid_i) begin
              case (op_e'(opcode_i))
                OP_RESEED: begin
                  state_q <= ST_PREP;
                  pend_q  <= 1'b1;
                end
                OP_SPREAD: begin
                  state_q <= sts_i.rows_lt2 ? ST_FINISH : ST_SP_RD;
                end
                OP_READ: begin
                  state_q <= ST_RD_ADDR;
                end
                default: begin
                  state_q <= ST_FINISH;
                end
              endcase
            end
          end
          ST_RD_ADDR: begin
            state_q <= ST_RD_MEM;
          end
          ST_RD_MEM: begin
            state_q <= ST_FINISH;
          end
          ST_SP_RD: begin
            state_q <= ST_SP_WR;
          end
          ST_SP_WR: begin
            state_q <= ST_FINISH;
          end
          ST_FINISH: begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/fire_dpath.sv */
// Datapath of the fire effect cell engine: registers, scan, heat store and output register.
`default_nettype none

module fire_dpath #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned HEAT_MAX = 36,
  localparam int unsigned HEAT_W  = $clog2(HEAT_MAX + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fire_pkg::fire_cmd_t             cmd_i,
  output fire_pkg::fire_sts_t                  sts_o,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_ready_i,
  input  wire logic [fire_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fire_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic [fire_pkg::OP_W-1:0]       opcode_i,
  input  wire logic [fire_pkg::RND_W-1:0]      rnd_i,
  input  wire logic [fire_pkg::POS_W-1:0]      read_col_i,
  input  wire logic [fire_pkg::POS_W-1:0]      read_row_i,
  output logic [HEAT_W-1:0]                    heat_o,
  output logic [fire_pkg::RGB_W-1:0]           color_rgb_o,
  output logic                                 frame_done_o
);
  import fire_pkg::*;

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(DEPTH + 1);
  localparam int unsigned TW    = SW + 2;
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW    = POS_W + CW + 1;

  // Configuration and derived sizes
  logic [CFG_W-1:0] cols_q, rows_q;
  logic [CW-1:0]    cols_eff;
  logic [RW-1:0]    rows_eff;
  logic [SW-1:0]    size_q, base_q;

  // Captured item
  op_e              op_q;
  logic [RND_W-1:0] rnd_q;
  logic [POS_W-1:0] rcol_q, rrow_q;

  // Scan position, clear counter, read address
  logic [CW-1:0]    scan_col_q;
  logic [RW-1:0]    scan_row_q;
  logic [AW-1:0]    src_q;
  logic [AW-1:0]    clr_q;
  logic [AW-1:0]    rd_idx_q;
  logic             in_range_q;
  logic             done_q;

  // Heat store
  logic [HEAT_W-1:0] mem [0:DEPTH-1];
  logic [HEAT_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [HEAT_W-1:0] mem_wd;

  // Spread target
  logic signed [TW-1:0] tgt;
  logic                 tgt_ok;
  logic [HEAT_W-1:0]    sp_wd;
  logic [HEAT_W-1:0]    clr_wd;

  // Scan advance
  logic [RW:0]       row_inc;
  logic [CW:0]       col_inc;
  logic [PW-1:0]     rd_lin;
  logic              rd_in;
  logic [PAL_IDX_W-1:0] pal_idx;

  // Output register
  logic [HEAT_W-1:0] heat_q;
  logic [RGB_W-1:0]  rgb_q;
  logic              fdone_q;

  // Clamp register values to the usable range
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = CW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(cols_q);
    end
    if (rows_q == '0) begin
      rows_eff = RW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_q);
    end
  end

  assign sts_o.cfg_wr   = cfg_valid_i && cfg_ready_i &&
                          ((cfg_index_i == REG_COLS) || (cfg_index_i == REG_ROWS));
  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
  assign sts_o.rows_lt2 = (rows_eff < RW'(2));

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i == REG_COLS) begin
        cols_q <= cfg_data_i;
      end else if (cfg_index_i == REG_ROWS) begin
        rows_q <= cfg_data_i;
      end
    end
  end

  // Track store size and start of the bottom row
  always_ff @(posedge clk_i) begin
    size_q <= SW'(rows_eff) * SW'(cols_eff);
    base_q <= SW'(rows_eff - RW'(1)) * SW'(cols_eff);
  end

  // Latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(opcode_i);
      rnd_q  <= rnd_i;
      rcol_q <= read_col_i;
      rrow_q <= read_row_i;
    end
  end

  // Read address and range check
  assign rd_lin = PW'(rrow_q) * PW'(cols_eff) + PW'(rcol_q);
  assign rd_in  = (32'(rcol_q) < 32'(cols_eff)) && (32'(rrow_q) < 32'(rows_eff));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_calc) begin
      rd_idx_q   <= AW'(rd_lin);
      in_range_q <= rd_in;
    end
  end

  // Spread target: straight above on a zero cell, else shifted by 1-rnd
  always_comb begin
    if (rd_q == '0) begin
      tgt   = $signed(TW'(src_q)) - $signed(TW'(cols_eff));
      sp_wd = '0;
    end else begin
      tgt   = $signed(TW'(src_q)) + $signed(TW'(1)) - $signed(TW'(rnd_q))
              - $signed(TW'(cols_eff));
      sp_wd = rd_q - HEAT_W'(rnd_q[0]);
    end
    tgt_ok = (tgt >= $signed(TW'(0))) && (tgt < $signed(TW'(size_q)));
  end

  // Clear value: heat source on the bottom row, zero elsewhere
  assign clr_wd = ((SW'(clr_q) >= base_q) && (SW'(clr_q) < size_q)) ?
                  HEAT_W'(HEAT_MAX) : '0;

  // Select the single store access of this cycle
  always_comb begin
    mem_we   = cmd_i.clr_wr || (cmd_i.sp_wr && tgt_ok);
    mem_re   = cmd_i.sp_rd || cmd_i.rd_mem;
    mem_addr = rd_idx_q;
    mem_wd   = clr_wd;
    if (cmd_i.clr_wr) begin
      mem_addr = clr_q;
    end else if (cmd_i.sp_wr) begin
      mem_addr = AW'(tgt);
      mem_wd   = sp_wd;
    end else if (cmd_i.sp_rd) begin
      mem_addr = src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Advance clear counter and scan position
  assign row_inc = (RW + 1)'(scan_row_q) + (RW + 1)'(1);
  assign col_inc = (CW + 1)'(scan_col_q) + (CW + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      scan_col_q <= '0;
      scan_row_q <= RW'(1);
      src_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        clr_q      <= '0;
        scan_col_q <= '0;
        scan_row_q <= RW'(1);
        src_q      <= AW'(cols_eff);
      end else if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end

      if (cmd_i.capture) begin
        done_q <= (op_e'(opcode_i) == OP_SPREAD) && sts_o.rows_lt2;
      end else if (cmd_i.sp_wr) begin
        done_q <= 1'b0;
        if (row_inc >= (RW + 1)'(rows_eff)) begin
          scan_row_q <= RW'(1);
          if (col_inc >= (CW + 1)'(cols_eff)) begin
            scan_col_q <= '0;
            src_q      <= AW'(cols_eff);
            done_q     <= 1'b1;
          end else begin
            scan_col_q <= CW'(col_inc);
            src_q      <= AW'(SW'(cols_eff) + SW'(col_inc));
          end
        end else begin
          scan_row_q <= RW'(row_inc);
          src_q      <= src_q + AW'(cols_eff);
        end
      end
    end
  end

  // Palette lookup with clamp to the last entry
  assign pal_idx = (32'(rd_q) > PAL_LAST) ? PAL_IDX_W'(PAL_LAST) : PAL_IDX_W'(rd_q);

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if ((op_q == OP_READ) && in_range_q) begin
        heat_q <= rd_q;
        rgb_q  <= PAL_TAB[pal_idx];
      end else begin
        heat_q <= '0;
        rgb_q  <= '0;
      end
      fdone_q <= (op_q == OP_SPREAD) && done_q;
    end
  end

  assign heat_o       = heat_q;
  assign color_rgb_o  = rgb_q;
  assign frame_done_o = fdone_q;

endmodule

`default_nettype wire
